// ----- src/grr_pkg.sv -----
// Package for the group reverse reorder block: sizes, buffer write and command types.
// Used by every module of the block; depends on nothing.
package grr_pkg;

  localparam int MaxGroup = 64;
  localparam int AddrW    = $clog2(MaxGroup);
  localparam int CntW     = $clog2(MaxGroup + 1);
  localparam int DataW    = 32;
  localparam int CfgW     = 7;
  localparam int CfgReset = 2;
  localparam int CmdDepth = 2;
  localparam int CmdPtrW  = $clog2(CmdDepth);

  typedef struct packed {
    logic                    en;
    logic [AddrW-1:0]        addr;
    logic signed [DataW-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [CntW-1:0] len;
    logic            rev;
    logic            last;
  } cmd_t;

endpackage

// ----- src/grr_front.sv -----
// Front end: accepts input transactions, holds the group size register and fill count,
// writes the group buffer and issues one drain command per finished run. Uses grr_pkg.
module grr_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [grr_pkg::DataW-1:0] item_value_i,
  input  logic                             list_last_i,
  input  logic                             cfg_we_i,
  input  logic [grr_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                             drain_busy_i,
  output grr_pkg::wr_t                     wr_o,
  output logic                             push_o,
  output grr_pkg::cmd_t                    cmd_o
);
  import grr_pkg::*;

  logic [CfgW-1:0] group_size_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] k_eff;
  logic [CntW-1:0] n_items;
  logic            accept;
  logic            complete;

  always_comb begin
    if (group_size_q == '0) begin
      k_eff = CntW'(1);
    end else if (CntW'(group_size_q) > CntW'(MaxGroup)) begin
      k_eff = CntW'(MaxGroup);
    end else begin
      k_eff = CntW'(group_size_q);
    end
  end

  assign in_ready_o = !drain_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign n_items    = fill_q + CntW'(1);
  assign complete   = n_items >= k_eff;

  assign wr_o.en   = accept;
  assign wr_o.addr = fill_q[AddrW-1:0];
  assign wr_o.data = item_value_i;

  assign push_o     = accept && (complete || list_last_i);
  assign cmd_o.len  = n_items;
  assign cmd_o.rev  = complete;
  assign cmd_o.last = list_last_i;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = push_o ? '0 : n_items;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      group_size_q <= CfgW'(CfgReset);
    end else begin
      fill_q <= fill_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q < CntW'(MaxGroup))
    else $error("fill count reached a full buffer without a drain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   accept && complete |-> push_o && cmd_o.rev)
    else $error("finished group not sent as reversed run");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |=> fill_q == '0)
    else $error("fill count not cleared after a run");

endmodule

// ----- src/grr_cmd_fifo.sv -----
// Short command queue between the front and back ends of the group reverse reorder block.
// Uses grr_pkg for the command type and depth.
module grr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  grr_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          valid_o,
  output grr_pkg::cmd_t cmd_o
);
  import grr_pkg::*;

  cmd_t               slots_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign valid_o = count_q != '0;
  assign cmd_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && (count_q != (CmdPtrW+1)'(CmdDepth));
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (CmdPtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (CmdPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + CmdPtrW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_i |-> count_q != (CmdPtrW+1)'(CmdDepth))
    else $error("command pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("command popped from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= (CmdPtrW+1)'(CmdDepth))
    else $error("command queue count out of range");

endmodule

// ----- src/grr_back.sv -----
// Back end: owns the group buffer memory and drains each run to the output port,
// newest first for full groups and in arrival order for a list tail. Uses grr_pkg.
module grr_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  grr_pkg::wr_t                     wr_i,
  input  logic                             cmd_valid_i,
  input  grr_pkg::cmd_t                    cmd_i,
  output logic                             pop_o,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [grr_pkg::DataW-1:0] out_value_o,
  output logic                             run_last_o,
  output logic                             list_end_o
);
  import grr_pkg::*;

  logic signed [DataW-1:0] mem [MaxGroup];
  logic signed [DataW-1:0] rd_data_q;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]         left_q, left_d;
  logic                    rev_q, rev_d;
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  logic                    run_last_q, list_end_q;
  logic                    issue;
  logic                    final_issue;

  assign busy_o      = left_q != '0;
  assign pop_o       = cmd_valid_i && !busy_o;
  assign issue       = busy_o && (!out_valid_q || out_ready_i);
  assign final_issue = left_q == CntW'(1);

  always_comb begin
    idx_d       = idx_q;
    left_d      = left_q;
    rev_d       = rev_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      left_d = cmd_i.len;
      rev_d  = cmd_i.rev;
      last_d = cmd_i.last;
      idx_d  = cmd_i.rev ? AddrW'(cmd_i.len - CntW'(1)) : '0;
    end else if (issue) begin
      left_d      = left_q - CntW'(1);
      idx_d       = rev_q ? idx_q - AddrW'(1) : idx_q + AddrW'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (issue) begin
      rd_data_q  <= mem[idx_q];
      run_last_q <= final_issue;
      list_end_q <= final_issue && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      left_q      <= '0;
      rev_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      left_q      <= left_d;
      rev_q       <= rev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = rd_data_q;
  assign run_last_o  = run_last_q;
  assign list_end_o  = list_end_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) left_q <= CntW'(MaxGroup))
    else $error("drain count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue && final_issue
                   |=> out_valid_q && run_last_q && (list_end_q == $past(last_q)))
    else $error("last read of a run not flagged");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i.en |-> !busy_o)
    else $error("buffer written while a run drains");

endmodule

// ----- src/group_reverse_reorder.sv -----
// Group reverse reorder: full groups of group_size items leave newest first, a list tail
// leaves in arrival order. A closing item pushes a command to the queue; the back end pops it,
// loads its drain state, then reads and registers results, one per cycle unless out_ready_i
// stalls, from the single group buffer. Input is held while a command waits or a run drains.
// Reset: asynchronous active low; clears fill count, queue and drain state, group_size = 2.
// Uses grr_pkg, grr_front, grr_cmd_fifo and grr_back.
module group_reverse_reorder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [grr_pkg::DataW-1:0] item_value_i,
  input  logic                             list_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [grr_pkg::DataW-1:0] out_value_o,
  output logic                             run_last_o,
  output logic                             list_end_o,
  input  logic                             cfg_we_i,
  input  logic [grr_pkg::CfgW-1:0]         cfg_wdata_i
);
  import grr_pkg::*;

  wr_t  wr;
  cmd_t push_cmd, head_cmd;
  logic push, pop, cmd_valid, back_busy;
  logic drain_busy;

  assign drain_busy = cmd_valid || back_busy;

  grr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .item_value_i,
    .list_last_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .drain_busy_i (drain_busy),
    .wr_o         (wr),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  grr_cmd_fifo u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  grr_back u_back (
    .clk_i,
    .rst_ni,
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .out_valid_o,
    .out_ready_i,
    .out_value_o,
    .run_last_o,
    .list_end_o
  );

endmodule

// ----- bench/testbench.sv -----
// Testbench for group_reverse_reorder: a directed table, then random lists under four
// idling phases; typed rows are checked against the table, the rest against an in-bench
// model of the group reversal. Depends on grr_pkg and the block RTL only.
module testbench;
  import grr_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 20;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    run_last;
    logic                    list_end;
  } result_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [CfgW-1:0]         size;
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    typed;
    result_t                 want;
  } row_t;

  localparam row_t Script [29] = '{
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h7fff_ffff, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0005, 1'b1, 1'b1, '{32'h0000_0005, 1'b1, 1'b1}},
    '{1'b1, 7'd1,   32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{1'b0, 7'd0,   32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1}},
    '{1'b1, 7'd0,   32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h8000_0000, 1'b0, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
    '{1'b0, 7'd0,   32'h5555_aaaa, 1'b1, 1'b1, '{32'h5555_aaaa, 1'b1, 1'b1}},
    '{1'b1, 7'd3,   32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0001, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0002, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0003, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_000a, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_000b, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_000c, 1'b1, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0014, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0015, 1'b1, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b1, 7'd4,   32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_001e, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_001f, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b1, 7'd2,   32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0020, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h0000_0021, 1'b1, 1'b1, '{32'h0000_0021, 1'b1, 1'b1}},
    '{1'b1, 7'd127, 32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'haaaa_5555, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h7fff_ffff, 1'b1, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b1, 7'd65,  32'h0000_0000, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
    '{1'b0, 7'd0,   32'h1234_5678, 1'b1, 1'b1, '{32'h1234_5678, 1'b1, 1'b1}}
  };

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic signed [DataW-1:0] item_value_i = '0;
  logic                    list_last_i  = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic signed [DataW-1:0] out_value_o;
  logic                    run_last_o;
  logic                    list_end_o;
  logic                    cfg_we_i     = 1'b0;
  logic [CfgW-1:0]         cfg_wdata_i  = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int err_cnt      = 0;
  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int cycle_cnt    = 0;

  result_t                 due_q [$];
  logic signed [DataW-1:0] held_buf [MaxGroup];
  int                      held_cnt   = 0;
  logic [CfgW-1:0]         grp_size_q = CfgW'(CfgReset);

  group_reverse_reorder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_value_i (item_value_i),
    .list_last_i  (list_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .run_last_o   (run_last_o),
    .list_end_o   (list_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void reverse_predict(input logic signed [DataW-1:0] v, input logic l,
                                          input bit emit);
    int k;
    int n;
    k = (grp_size_q == '0) ? 1 :
        ((int'(grp_size_q) > MaxGroup) ? MaxGroup : int'(grp_size_q));
    if (held_cnt < MaxGroup) begin
      held_buf[held_cnt] = v;
      held_cnt++;
    end
    n = held_cnt;
    if (n >= k || l) begin
      for (int i = 0; i < n; i++) begin
        if (emit && n >= k) begin
          due_q.push_back('{held_buf[n-1-i], i == n - 1, (i == n - 1) && l});
        end else if (emit) begin
          due_q.push_back('{held_buf[i], i == n - 1, i == n - 1});
        end
      end
      held_cnt = 0;
    end
  endfunction

  task automatic write_size(input logic [CfgW-1:0] size);
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    grp_size_q = size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(input logic signed [DataW-1:0] v, input logic l, input bit typed,
                           input result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    item_value_i <= v;
    list_last_i  <= l;
    do @(posedge clk_i); while (!in_ready_o);
    reverse_predict(v, l, !typed);
    if (typed) due_q.push_back(want);
    sent_cnt++;
  endtask

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) send_item($urandom, i == len - 1, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, got value %0d run_last %0b list_end %0b",
                 $time, out_value_o, run_last_o, list_end_o);
      end else begin
        want = due_q.pop_front();
        checked_cnt++;
        if (out_value_o !== want.value) begin
          err_cnt++;
          $display("%0t: out_value expected %0d, got %0d", $time, want.value, out_value_o);
        end
        if (run_last_o !== want.run_last) begin
          err_cnt++;
          $display("%0t: run_last expected %0b, got %0b", $time, want.run_last, run_last_o);
        end
        if (list_end_o !== want.list_end) begin
          err_cnt++;
          $display("%0t: list_end expected %0b, got %0b", $time, want.list_end, list_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_items;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < $size(Script); r++) begin
      if (Script[r].is_cfg) begin
        write_size(Script[r].size);
      end else begin
        send_item(Script[r].value, Script[r].last, Script[r].typed, Script[r].want);
      end
    end
    // fill one whole group at the largest size, then leave a short tail
    write_size(CfgW'(MaxGroup));
    send_list(MaxGroup + 2);
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = (p == 1) ? 76 : ((p == 3) ? 36 : 0);
      rx_stall_pct = (p == 2) ? 76 : ((p == 3) ? 36 : 0);
      write_size(CfgW'($urandom_range(1, 8)));
      phase_items = 0;
      while (phase_items < 5) begin
        len = $urandom_range(1, 6);
        send_list(len);
        phase_items += len;
        if ($urandom_range(2) == 0) write_size(CfgW'($urandom_range(1, 8)));
      end
    end
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("testbench: %0d items sent, %0d results compared", sent_cnt, checked_cnt);
    $display("testbench: sizes 0 to 127 incl. a full 64-item group, stalls on both sides");
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
